// File: rtl/dsrk_pkg.sv
// shared types, constants and the step micro-program of the spring integrator
package dsrk_pkg;

  // configuration port geometry
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int OUT_BITS      = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STIFFNESS      = 3'd0,
    REG_DAMPING        = 3'd1,
    REG_STEP_SIZE      = 3'd2,
    REG_START_POSITION = 3'd3,
    REG_START_VELOCITY = 3'd4
  } cfg_reg_e;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_NEG = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  // operand and destination codes: scratch entries below 16, named values from 16 up
  typedef enum logic [4:0] {
    SRC_T0    = 5'd0,
    SRC_T1    = 5'd1,
    SRC_AV    = 5'd2,
    SRC_BX    = 5'd3,
    SRC_BV    = 5'd4,
    SRC_CX    = 5'd5,
    SRC_CV    = 5'd6,
    SRC_DX    = 5'd7,
    SRC_DV    = 5'd8,
    SRC_X     = 5'd16,
    SRC_V     = 5'd17,
    SRC_K     = 5'd18,
    SRC_C     = 5'd19,
    SRC_H     = 5'd20,
    SRC_HALF  = 5'd21,
    SRC_SIXTH = 5'd22
  } src_e;

  // scratch register file
  localparam int RF_DEPTH = 9;
  localparam int RF_AW    = $clog2(RF_DEPTH);

  // micro-program length
  localparam int PROG_LEN = 46;
  localparam int PC_BITS  = $clog2(PROG_LEN);

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
  } uop_t;

  // request to and response from the shared unit
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic clip;
  } alu_rsp_t;

  // one rk4 step as a list of dependent operations
  function automatic uop_t prog_rom(input logic [PC_BITS-1:0] pc);
    uop_t u;
    u = '{OP_ADD, SRC_T0, SRC_T0, SRC_T0};
    case (pc)
      // a: acceleration at the current state
      6'd0:  u = '{OP_MUL, SRC_K,    SRC_X,     SRC_T0};
      6'd1:  u = '{OP_NEG, SRC_T0,   SRC_T0,    SRC_T0};
      6'd2:  u = '{OP_MUL, SRC_C,    SRC_V,     SRC_T1};
      6'd3:  u = '{OP_NEG, SRC_T1,   SRC_T1,    SRC_T1};
      6'd4:  u = '{OP_ADD, SRC_T0,   SRC_T1,    SRC_AV};
      // b: half step along a
      6'd5:  u = '{OP_MUL, SRC_AV,   SRC_HALF,  SRC_T0};
      6'd6:  u = '{OP_ADD, SRC_V,    SRC_T0,    SRC_BX};
      6'd7:  u = '{OP_MUL, SRC_V,    SRC_HALF,  SRC_T0};
      6'd8:  u = '{OP_ADD, SRC_X,    SRC_T0,    SRC_T0};
      6'd9:  u = '{OP_MUL, SRC_K,    SRC_T0,    SRC_T0};
      6'd10: u = '{OP_NEG, SRC_T0,   SRC_T0,    SRC_T0};
      6'd11: u = '{OP_MUL, SRC_C,    SRC_BX,    SRC_T1};
      6'd12: u = '{OP_NEG, SRC_T1,   SRC_T1,    SRC_T1};
      6'd13: u = '{OP_ADD, SRC_T0,   SRC_T1,    SRC_BV};
      // c: half step along b
      6'd14: u = '{OP_MUL, SRC_BV,   SRC_HALF,  SRC_T0};
      6'd15: u = '{OP_ADD, SRC_V,    SRC_T0,    SRC_CX};
      6'd16: u = '{OP_MUL, SRC_BX,   SRC_HALF,  SRC_T0};
      6'd17: u = '{OP_ADD, SRC_X,    SRC_T0,    SRC_T0};
      6'd18: u = '{OP_MUL, SRC_K,    SRC_T0,    SRC_T0};
      6'd19: u = '{OP_NEG, SRC_T0,   SRC_T0,    SRC_T0};
      6'd20: u = '{OP_MUL, SRC_C,    SRC_CX,    SRC_T1};
      6'd21: u = '{OP_NEG, SRC_T1,   SRC_T1,    SRC_T1};
      6'd22: u = '{OP_ADD, SRC_T0,   SRC_T1,    SRC_CV};
      // d: full step along c
      6'd23: u = '{OP_MUL, SRC_CV,   SRC_H,     SRC_T0};
      6'd24: u = '{OP_ADD, SRC_V,    SRC_T0,    SRC_DX};
      6'd25: u = '{OP_MUL, SRC_CX,   SRC_H,     SRC_T0};
      6'd26: u = '{OP_ADD, SRC_X,    SRC_T0,    SRC_T0};
      6'd27: u = '{OP_MUL, SRC_K,    SRC_T0,    SRC_T0};
      6'd28: u = '{OP_NEG, SRC_T0,   SRC_T0,    SRC_T0};
      6'd29: u = '{OP_MUL, SRC_C,    SRC_DX,    SRC_T1};
      6'd30: u = '{OP_NEG, SRC_T1,   SRC_T1,    SRC_T1};
      6'd31: u = '{OP_ADD, SRC_T0,   SRC_T1,    SRC_DV};
      // weighted position update
      6'd32: u = '{OP_ADD, SRC_BX,   SRC_CX,    SRC_T0};
      6'd33: u = '{OP_ADD, SRC_T0,   SRC_T0,    SRC_T0};
      6'd34: u = '{OP_ADD, SRC_V,    SRC_T0,    SRC_T0};
      6'd35: u = '{OP_ADD, SRC_T0,   SRC_DX,    SRC_T0};
      6'd36: u = '{OP_MUL, SRC_T0,   SRC_SIXTH, SRC_T0};
      6'd37: u = '{OP_MUL, SRC_T0,   SRC_H,     SRC_T0};
      6'd38: u = '{OP_ADD, SRC_X,    SRC_T0,    SRC_X};
      // weighted velocity update
      6'd39: u = '{OP_ADD, SRC_BV,   SRC_CV,    SRC_T0};
      6'd40: u = '{OP_ADD, SRC_T0,   SRC_T0,    SRC_T0};
      6'd41: u = '{OP_ADD, SRC_AV,   SRC_T0,    SRC_T0};
      6'd42: u = '{OP_ADD, SRC_T0,   SRC_DV,    SRC_T0};
      6'd43: u = '{OP_MUL, SRC_T0,   SRC_SIXTH, SRC_T0};
      6'd44: u = '{OP_MUL, SRC_T0,   SRC_H,     SRC_T0};
      6'd45: u = '{OP_ADD, SRC_V,    SRC_T0,    SRC_V};
      default: u = '{OP_ADD, SRC_T0, SRC_T0, SRC_T0};
    endcase
    return u;
  endfunction

endpackage

// File: rtl/dsrk_intf.sv
// handshake channels of the spring integrator: tick input, result output, register writes

interface dsrk_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface dsrk_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dsrk_pkg::OUT_BITS-1:0] position_out;
  logic signed [dsrk_pkg::OUT_BITS-1:0] velocity_out;
  logic                               saturated;

  modport source (output valid, output position_out, output velocity_out,
                  output saturated, input ready);
  modport sink (input valid, input position_out, input velocity_out,
                input saturated, output ready);
endinterface

interface dsrk_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [dsrk_pkg::CFG_IDX_BITS-1:0]     index;
  logic [dsrk_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/dsrk_rf.sv
// scratch register file, one write port and two registered read ports
module dsrk_rf #(
  parameter int W = 32
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [dsrk_pkg::RF_AW-1:0]     waddr_i,
  input  logic signed [W-1:0]            wdata_i,
  input  logic [dsrk_pkg::RF_AW-1:0]     raddr_a_i,
  input  logic [dsrk_pkg::RF_AW-1:0]     raddr_b_i,
  output logic signed [W-1:0]            rdata_a_o,
  output logic signed [W-1:0]            rdata_b_o
);
  import dsrk_pkg::*;

  logic signed [W-1:0] mem_q [RF_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/dsrk_mul.sv
// iterative fixed-point multiplier: four half-word partial products, sign fix, shift and clip
module dsrk_mul #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic                clip_o,
  output logic signed [W-1:0] result_o
);
  import dsrk_pkg::*;

  localparam int HB = (W + 1) / 2;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_PP   = 4'b0010,
    M_FIX  = 4'b0100,
    M_SAT  = 4'b1000
  } mul_state_e;

  mul_state_e        state_q, state_d;
  logic [1:0]        cnt_q;
  logic [W-1:0]      a_mag_q, b_mag_q;
  logic              neg_q;
  logic [PW-1:0]     acc_q, prod_q;
  logic              done_q, clip_q;
  logic [W-1:0]      res_q;

  logic [W-1:0]      a_mag, b_mag;
  logic [HB-1:0]     a_sel, b_sel;
  logic [2*HB-1:0]   pp;
  logic [PW-1:0]     pp_ext, pp_sh;
  logic [1:0]        sh_sel;
  logic signed [PW-1:0] shr;
  logic              ovf;

  // operand magnitudes
  assign a_mag = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag = b_i[W-1] ? (~b_i + 1'b1) : b_i;

  // current partial product and its weight
  assign a_sel  = cnt_q[1] ? HB'(a_mag_q[W-1:HB]) : a_mag_q[HB-1:0];
  assign b_sel  = cnt_q[0] ? HB'(b_mag_q[W-1:HB]) : b_mag_q[HB-1:0];
  assign pp     = a_sel * b_sel;
  assign pp_ext = PW'(pp);
  assign sh_sel = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};

  always_comb begin
    case (sh_sel)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << HB;
      default: pp_sh = pp_ext << (2 * HB);
    endcase
  end

  // drop fraction bits and check the word range
  assign shr = $signed(prod_q) >>> F;
  assign ovf = (shr[PW-1:W-1] != {(PW-W+1){shr[W-1]}});

  // sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE:  if (start_i) state_d = M_PP;
      M_PP:    if (cnt_q == 2'd3) state_d = M_FIX;
      M_FIX:   state_d = M_SAT;
      M_SAT:   state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_SAT);
      if (state_q == M_PP) begin
        cnt_q <= cnt_q + 2'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        a_mag_q <= a_mag;
        b_mag_q <= b_mag;
        neg_q   <= a_i[W-1] ^ b_i[W-1];
        acc_q   <= '0;
      end
      M_PP:  acc_q  <= acc_q + pp_sh;
      M_FIX: prod_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
      M_SAT: begin
        clip_q <= ovf;
        res_q  <= ovf ? (shr[PW-1] ? WMIN : WMAX) : shr[W-1:0];
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign clip_o   = clip_q;
  assign result_o = $signed(res_q);

endmodule

// File: rtl/dsrk_alu.sv
// shared arithmetic unit: combinational saturating add and negate, iterative multiply
module dsrk_alu #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsrk_pkg::alu_req_t    req_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output dsrk_pkg::alu_rsp_t    rsp_o,
  output logic signed [W-1:0]   result_o
);
  import dsrk_pkg::*;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W:0]          sum;
  logic                add_ovf;
  logic [W-1:0]        add_res;
  logic                neg_min;
  logic [W-1:0]        neg_res;
  logic                mul_done, mul_clip;
  logic signed [W-1:0] mul_res;
  logic [W-1:0]        fast_res;
  logic                fast_clip;

  // saturating add
  assign sum     = {a_i[W-1], a_i} + {b_i[W-1], b_i};
  assign add_ovf = sum[W] ^ sum[W-1];
  assign add_res = add_ovf ? (sum[W] ? WMIN : WMAX) : sum[W-1:0];

  // saturating negate
  assign neg_min = (a_i == WMIN);
  assign neg_res = neg_min ? WMAX : (~a_i + 1'b1);

  always_comb begin
    case (req_i.op)
      OP_ADD: begin
        fast_res  = add_res;
        fast_clip = add_ovf;
      end
      OP_NEG: begin
        fast_res  = neg_res;
        fast_clip = neg_min;
      end
      default: begin
        fast_res  = add_res;
        fast_clip = 1'b0;
      end
    endcase
  end

  dsrk_mul #(
    .W (W),
    .F (F)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (req_i.start && (req_i.op == OP_MUL)),
    .a_i      (a_i),
    .b_i      (b_i),
    .done_o   (mul_done),
    .clip_o   (mul_clip),
    .result_o (mul_res)
  );

  // response: fast ops finish in their start cycle, products when the multiplier is done
  always_comb begin
    if (mul_done) begin
      rsp_o.done = 1'b1;
      rsp_o.clip = mul_clip;
      result_o   = mul_res;
    end else begin
      rsp_o.done = req_i.start && (req_i.op != OP_MUL);
      rsp_o.clip = fast_clip;
      result_o   = $signed(fast_res);
    end
  end

endmodule

// File: rtl/damped_spring_rk4_step.sv
// damped spring integrator: one rk4 step per step tick on a shared arithmetic unit
// restart tick: loads the start position and velocity and hands them over as the result;
// a step tick runs 28 add/negate operations, and 18 products through the one shared
// multiplier, then hands over the result
// one tick at a time; the next tick is accepted once the result sits in the output register
// reset: position and velocity zero, registers at their defaults, no result pending
module damped_spring_rk4_step #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsrk_in_if.sink          in_i,
  dsrk_out_if.source       out_o,
  dsrk_cfg_if.sink         cfg_i
);
  import dsrk_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int EW = ((W > 32) ? W : 32) + 1;
  localparam logic signed [EW-1:0] WMAX_E = $signed({{(EW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam longint unsigned SIXTH_L = ((64'd1 << FRAC_BITS) + 64'd3) / 64'd6;
  localparam logic [W-1:0] SIXTH_W = W'(SIXTH_L);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_START = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  // clip a register value to the word range, flag on top
  function automatic logic [W:0] fit_word(input logic signed [EW-1:0] v);
    if (v > WMAX_E) begin
      return {1'b1, WMAX};
    end else if (v < WMIN_E) begin
      return {1'b1, WMIN};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  state_e                 state_q, state_d;
  logic [PC_BITS-1:0]     pc_q;
  logic signed [W-1:0]    position_q, velocity_q;
  logic                   sat_q;
  logic [30:0]            stiffness_q, damping_q, step_size_q;
  logic [31:0]            start_pos_q, start_vel_q;
  logic                   out_valid_q;
  logic [OUT_BITS-1:0]    pos_out_q, vel_out_q;
  logic                   sat_out_q;

  logic [W:0]             k_fit, c_fit, h_fit, sp_fit, sv_fit;
  logic [W-1:0]           half_w;
  uop_t                   uop;
  logic signed [W-1:0]    rf_a, rf_b, op_a, op_b, alu_res;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  logic                   in_acc, wb, last_op, out_free;
  logic                   rf_we;
  logic [EW-1:0]          pos_ext, vel_ext;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q <= 31'd655360;
      damping_q   <= 31'd65536;
      step_size_q <= 31'd65536;
      start_pos_q <= 32'd6554;
      start_vel_q <= 32'd1638400;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_STIFFNESS:      stiffness_q <= cfg_i.data[30:0];
        REG_DAMPING:        damping_q   <= cfg_i.data[30:0];
        REG_STEP_SIZE:      step_size_q <= cfg_i.data[30:0];
        REG_START_POSITION: start_pos_q <= cfg_i.data;
        REG_START_VELOCITY: start_vel_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // register values in word form
  assign k_fit  = fit_word($signed({{(EW-31){1'b0}}, stiffness_q}));
  assign c_fit  = fit_word($signed({{(EW-31){1'b0}}, damping_q}));
  assign h_fit  = fit_word($signed({{(EW-31){1'b0}}, step_size_q}));
  assign sp_fit = fit_word($signed({{(EW-32){start_pos_q[31]}}, start_pos_q}));
  assign sv_fit = fit_word($signed({{(EW-32){start_vel_q[31]}}, start_vel_q}));
  assign half_w = {1'b0, h_fit[W-1:1]};

  // current operation
  assign uop = prog_rom(pc_q);

  dsrk_rf #(
    .W (W)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (uop.dst[RF_AW-1:0]),
    .wdata_i   (alu_res),
    .raddr_a_i (uop.a[RF_AW-1:0]),
    .raddr_b_i (uop.b[RF_AW-1:0]),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  // operand selection
  function automatic logic [W-1:0] pick(input src_e s, input logic [W-1:0] rf_v,
                                        input logic [W-1:0] x, input logic [W-1:0] v,
                                        input logic [W-1:0] k, input logic [W-1:0] c,
                                        input logic [W-1:0] h, input logic [W-1:0] hh);
    logic [W-1:0] r;
    case (s)
      SRC_X:     r = x;
      SRC_V:     r = v;
      SRC_K:     r = k;
      SRC_C:     r = c;
      SRC_H:     r = h;
      SRC_HALF:  r = hh;
      SRC_SIXTH: r = SIXTH_W;
      default:   r = rf_v;
    endcase
    return r;
  endfunction

  assign op_a = $signed(pick(uop.a, rf_a, position_q, velocity_q, k_fit[W-1:0],
                             c_fit[W-1:0], h_fit[W-1:0], half_w));
  assign op_b = $signed(pick(uop.b, rf_b, position_q, velocity_q, k_fit[W-1:0],
                             c_fit[W-1:0], h_fit[W-1:0], half_w));

  assign alu_req.start = (state_q == ST_START);
  assign alu_req.op    = uop.op;

  dsrk_alu #(
    .W (W),
    .F (FRAC_BITS)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (op_a),
    .b_i      (op_b),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  // write-back control
  assign wb       = alu_rsp.done && (state_q == ST_START || state_q == ST_WAIT);
  assign rf_we    = wb && (uop.dst != SRC_X) && (uop.dst != SRC_V);
  assign last_op  = (pc_q == PC_BITS'(PROG_LEN - 1));
  assign out_free = !out_valid_q || out_o.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = in_i.restart ? ST_EMIT : ST_ISSUE;
      ST_ISSUE: state_d = ST_START;
      ST_START: begin
        if (wb) begin
          state_d = last_op ? ST_EMIT : ST_ISSUE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT:  if (wb) state_d = last_op ? ST_EMIT : ST_ISSUE;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state, position and velocity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pc_q       <= '0;
      position_q <= '0;
      velocity_q <= '0;
      sat_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pc_q <= '0;
        if (in_i.restart) begin
          position_q <= $signed(sp_fit[W-1:0]);
          velocity_q <= $signed(sv_fit[W-1:0]);
          sat_q      <= sp_fit[W] | sv_fit[W];
        end else begin
          sat_q <= k_fit[W] | c_fit[W] | h_fit[W];
        end
      end else if (wb) begin
        sat_q <= sat_q | alu_rsp.clip;
        if (!last_op) begin
          pc_q <= pc_q + 1'b1;
        end
        if (uop.dst == SRC_X) begin
          position_q <= alu_res;
        end
        if (uop.dst == SRC_V) begin
          velocity_q <= alu_res;
        end
      end
    end
  end

  // output register
  assign pos_ext = {{(EW-W){position_q[W-1]}}, position_q};
  assign vel_ext = {{(EW-W){velocity_q[W-1]}}, velocity_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      pos_out_q <= pos_ext[OUT_BITS-1:0];
      vel_out_q <= vel_ext[OUT_BITS-1:0];
      sat_out_q <= sat_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.position_out = $signed(pos_out_q);
  assign out_o.velocity_out = $signed(vel_out_q);
  assign out_o.saturated    = sat_out_q;

  // shared unit only answers while an operation is in flight
  a_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == ST_START || state_q == ST_WAIT))
    else $error("shared unit response outside an operation");

  // program counter stays inside the micro-program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < PC_BITS'(PROG_LEN))
    else $error("program counter beyond the step program");

  // a step transaction starts the program from its first operation
  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.restart) |=> (state_q == ST_ISSUE && pc_q == '0))
    else $error("step did not start at the first operation");

  // a finished result waits while the previous one is still held
  a_emit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && !out_o.ready) |=> (state_q == ST_EMIT))
    else $error("result overwrote a pending transaction");

endmodule
